### sv/touch_contact_tap_detector_core_macros.svh
// Assertion macros used by the tap detector back end.
`ifndef TOUCH_CONTACT_TAP_DETECTOR_CORE_MACROS_SVH
`define TOUCH_CONTACT_TAP_DETECTOR_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCTD_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tap detector check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TCTD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tap detector check failed");

`endif

### sv/tctd_pkg.sv
// Types, constants and register codes shared by the tap detector modules.
`timescale 1ns / 1ps

package tctd_pkg;

   localparam int DEF_NUM_PADS         = 4;
   localparam int DEF_CONTACTS_PER_PAD = 2;
   localparam int DEF_QUEUE_DEPTH      = 2;

   localparam int PAD_IDX_W  = 4;
   localparam int SLOT_IDX_W = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CFG_PADS   = 4;

   localparam logic [15:0] SIZE_RESET       = 16'h7FFF;
   localparam logic [15:0] MOVE_LIMIT_RESET = 16'd100;
   localparam logic [31:0] TIME_LIMIT_RESET = 32'd200000;
   localparam logic [2:0]  JOYSTICK_MODE    = 3'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAD_IN_USE     = 3'd0,
      REG_PAD_MODES      = 3'd1,
      REG_PAD_WIDTHS     = 3'd2,
      REG_PAD_HEIGHTS    = 3'd3,
      REG_TAP_MOVE_LIMIT = 3'd4,
      REG_TAP_TIME_LIMIT = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [1:0]         pad_index;
      logic               contact_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic               touching;
      logic [63:0]        timestamp;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               button_down;
      logic               axis_valid;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
   } rsp_type;

   typedef struct packed {
      logic [CFG_PADS-1:0]       pad_in_use;
      logic [CFG_PADS-1:0][2:0]  pad_modes;
      logic [CFG_PADS-1:0][15:0] pad_widths;
      logic [CFG_PADS-1:0][15:0] pad_heights;
      logic [15:0]               tap_move_limit;
      logic [31:0]               tap_time_limit;
   } cfg_type;

   typedef struct packed {
      logic                  rejected;
      logic                  joystick;
      logic [PAD_IDX_W-1:0]  pad;
      logic                  contact;
      logic [SLOT_IDX_W-1:0] slot;
      logic [SLOT_IDX_W-1:0] base_slot;
      logic                  touching;
      logic [15:0]           pos_x;
      logic [15:0]           pos_y;
      logic [63:0]           timestamp;
      logic [15:0]           center_x;
      logic [15:0]           center_y;
      logic [15:0]           size_x;
      logic [15:0]           size_y;
   } cmd_type;

   typedef struct packed {
      logic can_push;
      logic can_pop;
   } queue_status_type;

endpackage

### sv/tctd_queue.sv
// Short command queue between the classifying front and the state-updating back.
`timescale 1ns / 1ps

module tctd_queue #(
   parameter int DEPTH = tctd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tctd_pkg::cmd_type          push_data,
   input  logic                       pop,
   output tctd_pkg::cmd_type          pop_data,
   output tctd_pkg::queue_status_type status
);
   import tctd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data        = entry_ff[rd_ptr_ff];
   assign status.can_push = (count_ff < CntW'(DEPTH));
   assign status.can_pop  = (count_ff != '0);

endmodule

### sv/tctd_front.sv
// Front end: takes report beats, checks the pad and slot, and queues a command.
`timescale 1ns / 1ps

module tctd_front #(
   parameter int NUM_PADS         = tctd_pkg::DEF_NUM_PADS,
   parameter int CONTACTS_PER_PAD = tctd_pkg::DEF_CONTACTS_PER_PAD
) (
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tctd_pkg::req_type          req_data,
   input  tctd_pkg::cfg_type          cfg,
   input  tctd_pkg::queue_status_type queue_status,
   output logic                       push,
   output tctd_pkg::cmd_type          cmd
);
   import tctd_pkg::*;

   logic        rejected;
   logic [1:0]  pad;
   logic [15:0] size_x;
   logic [15:0] size_y;

   assign pad    = req_data.pad_index;
   assign size_x = cfg.pad_widths[pad];
   assign size_y = cfg.pad_heights[pad];

   assign rejected = (int'(pad) >= NUM_PADS)
                  || (int'(req_data.contact_index) >= CONTACTS_PER_PAD)
                  || !cfg.pad_in_use[pad];

   always_comb begin
      cmd           = '0;
      cmd.rejected  = rejected;
      cmd.joystick  = (cfg.pad_modes[pad] == JOYSTICK_MODE);
      cmd.contact   = req_data.contact_index;
      cmd.touching  = req_data.touching;
      cmd.pos_x     = req_data.pos_x;
      cmd.pos_y     = req_data.pos_y;
      cmd.timestamp = req_data.timestamp;
      cmd.size_x    = size_x;
      cmd.size_y    = size_y;
      cmd.center_x  = {req_data.pos_x[14:0], 1'b0} - size_x;
      cmd.center_y  = {req_data.pos_y[14:0], 1'b0} - size_y;
      if (!rejected) begin
         cmd.pad       = PAD_IDX_W'(pad);
         cmd.slot      = SLOT_IDX_W'(int'(pad) * CONTACTS_PER_PAD
                                     + int'(req_data.contact_index));
         cmd.base_slot = SLOT_IDX_W'(int'(pad) * CONTACTS_PER_PAD);
      end
   end

   assign req_ready = queue_status.can_push;
   assign push      = req_valid && queue_status.can_push;

endmodule

### sv/tctd_back.sv
// Back end: updates the contact state, decides taps and registers the result beat.
`timescale 1ns / 1ps
`include "touch_contact_tap_detector_core_macros.svh"

module tctd_back #(
   parameter int NUM_PADS         = tctd_pkg::DEF_NUM_PADS,
   parameter int CONTACTS_PER_PAD = tctd_pkg::DEF_CONTACTS_PER_PAD
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tctd_pkg::cfg_type          cfg,
   input  tctd_pkg::queue_status_type queue_status,
   input  tctd_pkg::cmd_type          cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tctd_pkg::rsp_type          rsp_data
);
   import tctd_pkg::*;

   localparam int Slots = NUM_PADS * CONTACTS_PER_PAD;
   localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
   localparam int PadW  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

   logic [Slots-1:0]    active_ff, active_in;
   logic [Slots-1:0]    cand_ff, cand_in;
   logic [NUM_PADS-1:0] button_ff, button_in;
   logic [15:0]         start_x_ff [Slots];
   logic [15:0]         start_y_ff [Slots];
   logic [63:0]         start_time_ff [Slots];
   logic [15:0]         cur_x_ff [Slots];
   logic [15:0]         cur_y_ff [Slots];
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SlotW-1:0] s;
   logic [SlotW-1:0] s0;
   logic [PadW-1:0]  p;
   logic             update;
   logic             slot_active;
   logic             slot_cand;
   logic [16:0]      dx, dy, mag_x, mag_y;
   logic             moved_far;
   logic [63:0]      elapsed;
   logic             tap_ok;
   logic             release_now;
   logic             button_new;
   logic [15:0]      base_x, base_y;

   assign s  = cmd.slot[SlotW-1:0];
   assign s0 = cmd.base_slot[SlotW-1:0];
   assign p  = cmd.pad[PadW-1:0];

   assign pop    = queue_status.can_pop && (!rsp_valid_ff || rsp_ready);
   assign update = pop && !cmd.rejected;

   assign slot_active = active_ff[s];
   assign slot_cand   = cand_ff[s];

   assign dx    = {cmd.pos_x[15], cmd.pos_x} - {start_x_ff[s][15], start_x_ff[s]};
   assign dy    = {cmd.pos_y[15], cmd.pos_y} - {start_y_ff[s][15], start_y_ff[s]};
   assign mag_x = dx[16] ? (17'd0 - dx) : dx;
   assign mag_y = dy[16] ? (17'd0 - dy) : dy;
   assign moved_far = (mag_x > {1'b0, cfg.tap_move_limit})
                   || (mag_y > {1'b0, cfg.tap_move_limit});

   assign elapsed = cmd.timestamp - start_time_ff[s];
   assign tap_ok  = slot_cand && (elapsed[63:32] == '0)
                 && (elapsed[31:0] < cfg.tap_time_limit);

   assign release_now = slot_active && !cmd.touching;
   assign button_new  = release_now ? tap_ok : button_ff[p];

   assign base_x = {cur_x_ff[s0][14:0], 1'b0} - cmd.size_x;
   assign base_y = {cur_y_ff[s0][14:0], 1'b0} - cmd.size_y;

   always_comb begin
      active_in = active_ff;
      cand_in   = cand_ff;
      button_in = button_ff;
      if (update) begin
         if (!slot_active && cmd.touching) begin
            cand_in[s] = 1'b1;
         end else if (slot_active && cmd.touching && slot_cand && moved_far) begin
            cand_in[s] = 1'b0;
         end
         if (release_now) begin
            button_in[p] = tap_ok;
         end
         active_in[s] = cmd.touching;
      end
   end

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = cmd.rejected;
      if (!cmd.rejected) begin
         rsp_in.button_down = button_new;
         rsp_in.axis_valid  = cmd.joystick;
         if (cmd.joystick) begin
            if (!cmd.contact) begin
               if (cmd.touching) begin
                  rsp_in.axis_x = cmd.center_x;
                  rsp_in.axis_y = cmd.center_y;
               end
            end else if (active_ff[s0]) begin
               rsp_in.axis_x = base_x;
               rsp_in.axis_y = base_y;
            end
         end
      end
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         cand_ff      <= '0;
         button_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cand_ff      <= cand_in;
         button_ff    <= button_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         cur_x_ff[s] <= cmd.pos_x;
         cur_y_ff[s] <= cmd.pos_y;
         if (!slot_active && cmd.touching) begin
            start_x_ff[s]    <= cmd.pos_x;
            start_y_ff[s]    <= cmd.pos_y;
            start_time_ff[s] <= cmd.timestamp;
         end
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCTD_ASSERT_NEXT(a_pop_gives_beat, pop, rsp_valid_ff)
   `TCTD_ASSERT_SAME(a_reject_is_clean, rsp_valid_ff && rsp_ff.status,
      !rsp_ff.button_down && !rsp_ff.axis_valid && rsp_ff.axis_x == '0 && rsp_ff.axis_y == '0)
   `TCTD_ASSERT_SAME(a_no_axis_outside_joystick, rsp_valid_ff && !rsp_ff.axis_valid,
      rsp_ff.axis_x == '0 && rsp_ff.axis_y == '0)

endmodule

### sv/touch_contact_tap_detector_core.sv
// A report beat passes through the command queue and then the back end's result register.
// Throughput: one beat per cycle while the result beat is not held by a low rsp_ready.
// The two-entry command queue lets the input keep flowing while a result beat is held.
// Reset is synchronous: it clears contact flags, tap candidates, button bits and the queue,
// and returns every configuration register to its default value.
`timescale 1ns / 1ps

module touch_contact_tap_detector_core #(
   parameter int NUM_PADS         = tctd_pkg::DEF_NUM_PADS,
   parameter int CONTACTS_PER_PAD = tctd_pkg::DEF_CONTACTS_PER_PAD,
   parameter int QUEUE_DEPTH      = tctd_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tctd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tctd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [tctd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tctd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tctd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   cmd_type          push_cmd;
   cmd_type          pop_cmd;
   logic             push;
   logic             pop;
   queue_status_type queue_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_PAD_IN_USE:     cfg_in.pad_in_use     = csr_wdata[CFG_PADS-1:0];
            REG_PAD_MODES:      cfg_in.pad_modes      = csr_wdata[3*CFG_PADS-1:0];
            REG_PAD_WIDTHS:     cfg_in.pad_widths     = csr_wdata[16*CFG_PADS-1:0];
            REG_PAD_HEIGHTS:    cfg_in.pad_heights    = csr_wdata[16*CFG_PADS-1:0];
            REG_TAP_MOVE_LIMIT: cfg_in.tap_move_limit = csr_wdata[15:0];
            REG_TAP_TIME_LIMIT: cfg_in.tap_time_limit = csr_wdata[31:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_in_use     <= '0;
         cfg_ff.pad_modes      <= '0;
         cfg_ff.pad_widths     <= {CFG_PADS{SIZE_RESET}};
         cfg_ff.pad_heights    <= {CFG_PADS{SIZE_RESET}};
         cfg_ff.tap_move_limit <= MOVE_LIMIT_RESET;
         cfg_ff.tap_time_limit <= TIME_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tctd_front #(
      .NUM_PADS         (NUM_PADS),
      .CONTACTS_PER_PAD (CONTACTS_PER_PAD)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .push         (push),
      .cmd          (push_cmd)
   );

   tctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .status    (queue_status)
   );

   tctd_back #(
      .NUM_PADS         (NUM_PADS),
      .CONTACTS_PER_PAD (CONTACTS_PER_PAD)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .cmd          (pop_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
